[design/shp_pkg.sv]
// Shared types, round constants and initial values for the SHA-224/SHA-256 core.
package shp_pkg;

   // Input item as seen on the request channel.
   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        last;
   } req_payload_type;

   // Result item as seen on the response channel.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   // Classified item passed from the front queue to the engine.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } item_type;

   // Queue status and head item toward the engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } front_out_type;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   localparam logic VariantSha256 = 1'b0;
   localparam logic VariantSha224 = 1'b1;

   localparam logic [5:0] LengthFill = 6'd56;
   localparam logic [7:0] PadMarker  = 8'h80;

   // Round constant for round t.
   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Initial chaining word idx of the selected variant.
   function automatic logic [31:0] iv_word(input logic variant, input logic [2:0] idx);
      logic [31:0] w;
      if (variant == VariantSha224) begin
         unique case (idx)
            3'd0: w = 32'hc1059ed8; 3'd1: w = 32'h367cd507;
            3'd2: w = 32'h3070dd17; 3'd3: w = 32'hf70e5939;
            3'd4: w = 32'hffc00b31; 3'd5: w = 32'h68581511;
            3'd6: w = 32'h64f98fa7; 3'd7: w = 32'hbefa4fa4;
            default: w = 32'h0;
         endcase
      end else begin
         unique case (idx)
            3'd0: w = 32'h6a09e667; 3'd1: w = 32'hbb67ae85;
            3'd2: w = 32'h3c6ef372; 3'd3: w = 32'ha54ff53a;
            3'd4: w = 32'h510e527f; 3'd5: w = 32'h9b05688c;
            3'd6: w = 32'h1f83d9ab; 3'd7: w = 32'h5be0cd19;
            default: w = 32'h0;
         endcase
      end
      return w;
   endfunction

endpackage

[design/sha224_sha256_hash_core_top.sv]
// Top level of the streaming SHA-224/SHA-256 hash core.
//
//   channel | ports                           | accepted when
//   --------+---------------------------------+-------------------------------
//   request | req_push, req_full, req_data    | req_push && !req_full
//   result  | rsp_pop, rsp_empty, rsp_data    | rsp_pop && !rsp_empty
//   config  | csr_valid, csr_ready, csr_data  | csr_valid && csr_ready
//
// An item leaves the queue in S_IDLE, is packed into the block one byte at a
// time in S_BYTE and is then closed. Every full block runs 64 rounds in S_ROUND
// plus a chaining add in S_ADD, on the single shared round unit.
// Closing a message pads byte by byte up to byte 56 and then writes the length
// words. It then runs one or two compressions and sends 8 or 7 digest words,
// one per cycle while the result side pops.
// A four-entry request queue keeps taking items while the engine works.
// Reset is synchronous; it selects SHA-256 and loads its initial value.
module sha224_sha256_hash_core_top import shp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_payload_type req_data,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   front_out_type head;
   logic          pop;

   assign csr_ready = 1'b1;

   // Front queue.
   shp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .head     (head),
      .pop      (pop)
   );

   // Hash engine.
   shp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[design/shp_front.sv]
// Front queue: accepts request items, saturates the byte count and buffers them.
module shp_front import shp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_payload_type req_data,
   output front_out_type   head,
   input  logic            pop
);

   item_type                 queue_ff [QueueDepth];
   logic [QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]       count_ff, count_in;
   logic                     push_ok;
   logic                     pop_ok;
   item_type                 classified;

   // Byte counts above four mean a full word.
   always_comb begin
      classified.word   = req_data.message_word;
      classified.nbytes = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
      classified.last   = req_data.last;
   end

   assign req_full = (count_ff == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[design/shp_engine.sv]
// Hash engine: byte packing, padding, 64-round compression and digest output.
module shp_engine import shp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  front_out_type   head,
   output logic            pop,
   input  logic            csr_write,
   input  logic            csr_value,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_BYTE, S_PAD, S_ROUND, S_ADD, S_EMIT
   } state_type;

   state_type        state_ff;
   logic             variant_ff;
   logic [31:0]      chain_ff [8];
   logic [31:0]      buf_ff [16];
   logic [31:0]      v_ff [8];
   logic [5:0]       fill_ff;
   logic [63:0]      bits_ff;
   logic [31:0]      word_ff;
   logic [2:0]       nleft_ff;
   logic             last_ff;
   logic             pad_mode_ff;
   logic             pad_first_ff;
   logic             final_ff;
   logic [5:0]       round_ff;
   logic [2:0]       emit_idx_ff;
   logic             out_valid_ff;
   rsp_payload_type  out_ff;

   logic [7:0]       put_byte;
   logic [3:0]       put_idx;
   logic [1:0]       put_lane;
   logic [4:0]       put_shift;
   logic [31:0]      put_merged;
   logic [31:0]      s0, s1, w_new;
   logic [31:0]      sig0, sig1, ch, maj, t1, t2;
   logic [2:0]       last_idx;
   logic             out_free;

   assign pop       = (state_ff == S_IDLE) && head.valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign last_idx  = (variant_ff == VariantSha224) ? 3'd6 : 3'd7;

   // Byte insertion into the block buffer at the current fill position.
   always_comb begin
      if (state_ff == S_PAD) begin
         put_byte = pad_first_ff ? PadMarker : 8'h00;
      end else begin
         put_byte = word_ff[31:24];
      end
      put_idx    = fill_ff[5:2];
      put_lane   = fill_ff[1:0];
      put_shift  = {~put_lane, 3'b000};
      put_merged = ((put_lane == 2'd0) ? 32'h0 : buf_ff[put_idx])
                   | ({24'h0, put_byte} << put_shift);
   end

   // Message schedule and round function.
   always_comb begin
      s0    = {buf_ff[1][6:0], buf_ff[1][31:7]} ^ {buf_ff[1][17:0], buf_ff[1][31:18]}
              ^ (buf_ff[1] >> 3);
      s1    = {buf_ff[14][16:0], buf_ff[14][31:17]} ^ {buf_ff[14][18:0], buf_ff[14][31:19]}
              ^ (buf_ff[14] >> 10);
      w_new = buf_ff[0] + s0 + buf_ff[9] + s1;
      sig1  = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
              ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + sig1 + ch + round_k(round_ff) + buf_ff[0];
      sig0  = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
              ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = sig0 + maj;
   end

   // Sequencer with all state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         variant_ff   <= VariantSha256;
         fill_ff      <= '0;
         bits_ff      <= '0;
         pad_mode_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         final_ff     <= 1'b0;
         round_ff     <= '0;
         emit_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
         nleft_ff     <= '0;
         last_ff      <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= iv_word(VariantSha256, 3'(i));
         end
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         // A variant write restarts the message.
         if (csr_write) begin
            variant_ff <= csr_value;
            fill_ff    <= '0;
            bits_ff    <= '0;
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= iv_word(csr_value, 3'(i));
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  word_ff     <= head.item.word;
                  nleft_ff    <= head.item.nbytes;
                  last_ff     <= head.item.last;
                  bits_ff     <= bits_ff + {58'h0, head.item.nbytes, 3'b000};
                  pad_mode_ff <= 1'b0;
                  final_ff    <= 1'b0;
                  state_ff    <= S_BYTE;
               end
            end
            S_BYTE: begin
               if (nleft_ff == 3'd0) begin
                  if (last_ff) begin
                     pad_mode_ff  <= 1'b1;
                     pad_first_ff <= 1'b1;
                     state_ff     <= S_PAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  buf_ff[put_idx] <= put_merged;
                  word_ff         <= {word_ff[23:0], 8'h00};
                  nleft_ff        <= nleft_ff - 3'd1;
                  fill_ff         <= fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     v_ff     <= chain_ff;
                     round_ff <= '0;
                     state_ff <= S_ROUND;
                  end
               end
            end
            S_PAD: begin
               if (!pad_first_ff && fill_ff == LengthFill) begin
                  // Length words close the final block.
                  buf_ff[14] <= bits_ff[63:32];
                  buf_ff[15] <= bits_ff[31:0];
                  final_ff   <= 1'b1;
                  v_ff       <= chain_ff;
                  round_ff   <= '0;
                  state_ff   <= S_ROUND;
               end else begin
                  buf_ff[put_idx] <= put_merged;
                  pad_first_ff    <= 1'b0;
                  fill_ff         <= fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     v_ff     <= chain_ff;
                     round_ff <= '0;
                     state_ff <= S_ROUND;
                  end
               end
            end
            S_ROUND: begin
               // One round a cycle; the buffer doubles as the schedule window.
               for (int i = 0; i < 15; i++) begin
                  buf_ff[i] <= buf_ff[i+1];
               end
               buf_ff[15] <= w_new;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + v_ff[i];
               end
               emit_idx_ff <= '0;
               if (final_ff) begin
                  state_ff <= S_EMIT;
               end else if (pad_mode_ff) begin
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_BYTE;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  out_valid_ff      <= 1'b1;
                  out_ff.digest_word <= chain_ff[emit_idx_ff];
                  out_ff.word_index  <= emit_idx_ff;
                  out_ff.last_word   <= (emit_idx_ff == last_idx);
                  emit_idx_ff        <= emit_idx_ff + 3'd1;
                  if (emit_idx_ff == last_idx) begin
                     // Ready for the next message.
                     fill_ff     <= '0;
                     bits_ff     <= '0;
                     pad_mode_ff <= 1'b0;
                     final_ff    <= 1'b0;
                     for (int i = 0; i < 8; i++) begin
                        chain_ff[i] <= iv_word(variant_ff, 3'(i));
                     end
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The final compression always leads straight to digest output.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && final_ff) |=> (state_ff == S_EMIT))
      else $error("final block did not lead to digest output");

   // A new result is loaded only while the digest is being sent.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result loaded outside digest output");

   // Items leave the queue only when the engine is idle.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE && head.valid))
      else $error("item taken while engine busy");

endmodule
